[design/binary_to_decimal_ascii_defines.svh]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_defines.svh
// assertion macros for the converter rtl
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// checked on every clock edge outside reset
`define B2DA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define B2DA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/b2da_pkg.sv]
// ---------------------------------------------------------------------------
// b2da_pkg
// shared types and constants for the binary to decimal ascii converter
// ---------------------------------------------------------------------------
package b2da_pkg;

   localparam int MAX_DIGITS_DEF = 10;
   localparam int VALUE_BITS_DEF = 31;
   localparam int DIGIT_W        = 4;
   localparam int CHAR_W         = 6;

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'h30;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_STRIP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      BCD_HOLD,
      BCD_CLEAR,
      BCD_DABBLE,
      BCD_SHIFT_DIGIT
   } bcd_op_type;

   typedef struct packed {
      bcd_op_type op;
      logic       serial_in;
   } bcd_ctrl_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] top_digit;
      logic               carry_out;
   } bcd_stat_type;

endpackage

[design/b2da_bcd_reg.sv]
// ---------------------------------------------------------------------------
// b2da_bcd_reg
// packed bcd shift register with add-3 correction per digit lane
// ---------------------------------------------------------------------------
module b2da_bcd_reg #(
   parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
   input  logic                   clock,
   input  b2da_pkg::bcd_ctrl_type ctrl,
   output b2da_pkg::bcd_stat_type stat
);

   localparam int BCD_W = b2da_pkg::DIGIT_W * MAX_DIGITS;

   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] bcd_in;
   logic [BCD_W-1:0] adj;

   // each lane adds three when it would reach ten after doubling
   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_lane
      logic [b2da_pkg::DIGIT_W-1:0] d;
      assign d = bcd_ff[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
      assign adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
         (d >= 4'd5) ? d + 4'd3 : d;
   end

   always_comb begin
      case (ctrl.op)
         b2da_pkg::BCD_CLEAR:       bcd_in = '0;
         b2da_pkg::BCD_DABBLE:      bcd_in = {adj[BCD_W-2:0], ctrl.serial_in};
         b2da_pkg::BCD_SHIFT_DIGIT: bcd_in = bcd_ff << b2da_pkg::DIGIT_W;
         default:                   bcd_in = bcd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
   end

   assign stat.top_digit = bcd_ff[BCD_W-1 -: b2da_pkg::DIGIT_W];
   assign stat.carry_out = adj[BCD_W-1];

endmodule

[design/binary_to_decimal_ascii.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// converts one unsigned integer to decimal ascii digits, msd first
// ---------------------------------------------------------------------------
// A value is taken when start is high and busy low. It is shifted msb first
// into a bcd register with add-3 correction, one bit per cycle, then leading
// zero digits are dropped one per cycle and the remaining digits come out one
// per cycle on rsp_digit_char with rsp_valid high, rsp_last on the final one.
// Only the MAX_DIGITS least significant digits are kept; a value with more
// digits gives all MAX_DIGITS of them, zeros included. busy is high from the
// conversion through the final digit, so a new value can follow only once the
// last one is through; at the defaults the bit-serial conversion loop takes
// most of that time. Results cannot be stalled: each digit is on the ports
// for one cycle only.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF,
   parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_valid,
   output logic [b2da_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                          rsp_last
);

   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int DIG_W = $clog2(MAX_DIGITS + 1);

   b2da_pkg::state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]       dig_cnt_ff, dig_cnt_in;
   logic                   ovf_ff, ovf_in;
   b2da_pkg::bcd_ctrl_type bcd_ctrl;
   b2da_pkg::bcd_stat_type bcd_stat;
   logic                   accept;

   assign accept = start && (state_ff == b2da_pkg::ST_IDLE);

   b2da_bcd_reg #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_bcd (
      .clock(clock),
      .ctrl (bcd_ctrl),
      .stat (bcd_stat)
   );

   always_comb begin
      state_in           = state_ff;
      value_in           = value_ff;
      bit_cnt_in         = bit_cnt_ff;
      dig_cnt_in         = dig_cnt_ff;
      ovf_in             = ovf_ff;
      bcd_ctrl.op        = b2da_pkg::BCD_HOLD;
      bcd_ctrl.serial_in = value_ff[VALUE_BITS-1];
      case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (accept) begin
               value_in    = req_value;
               bit_cnt_in  = CNT_W'(VALUE_BITS);
               ovf_in      = 1'b0;
               bcd_ctrl.op = b2da_pkg::BCD_CLEAR;
               state_in    = b2da_pkg::ST_CONVERT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            bcd_ctrl.op = b2da_pkg::BCD_DABBLE;
            value_in    = value_ff << 1;
            bit_cnt_in  = bit_cnt_ff - CNT_W'(1);
            // a set bit pushed out of the top digit means the value is too long
            ovf_in      = ovf_ff | bcd_stat.carry_out;
            if (bit_cnt_ff == CNT_W'(1)) begin
               dig_cnt_in = DIG_W'(MAX_DIGITS);
               state_in   = b2da_pkg::ST_STRIP;
            end
         end
         b2da_pkg::ST_STRIP: begin
            if (bcd_stat.top_digit == '0 && !ovf_ff && dig_cnt_ff != DIG_W'(1)) begin
               bcd_ctrl.op = b2da_pkg::BCD_SHIFT_DIGIT;
               dig_cnt_in  = dig_cnt_ff - DIG_W'(1);
            end else begin
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            bcd_ctrl.op = b2da_pkg::BCD_SHIFT_DIGIT;
            dig_cnt_in  = dig_cnt_ff - DIG_W'(1);
            if (dig_cnt_ff == DIG_W'(1)) begin
               state_in = b2da_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= b2da_pkg::ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign busy           = (state_ff != b2da_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == b2da_pkg::ST_EMIT);
   assign rsp_digit_char = b2da_pkg::ASCII_ZERO
                         + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}},
                            bcd_stat.top_digit};
   assign rsp_last       = rsp_valid && (dig_cnt_ff == DIG_W'(1));

   `B2DA_ASSERT(a_digit_range, rsp_valid |-> (bcd_stat.top_digit <= b2da_pkg::DIGIT_MAX), "digit out of decimal range")
   `B2DA_ASSERT(a_digits_contiguous, (rsp_valid && !rsp_last) |=> rsp_valid, "gap inside a digit string")
   `B2DA_ASSERT(a_last_frees, (rsp_valid && rsp_last) |=> !busy, "still busy after final digit")
   `B2DA_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !rsp_valid), "accepted transfer did not start conversion")
   `B2DA_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy, "not idle after reset")

endmodule

[tb/sv/binary_to_decimal_ascii_tb.sv]
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// self-checking bench for the binary to decimal ascii converter
// ---------------------------------------------------------------------------
// A short table of directed values is run first. Zero, one, nine, ten, the
// largest value and 1000000000 carry their digit string typed in, and the
// other rows are predicted. Random values of every decimal length follow in
// four phases, two of them with sender idling. Each digit seen on the result
// ports is compared with the oldest expected digit.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VBITS        = b2da_pkg::VALUE_BITS_DEF;
   localparam int NDIGITS      = b2da_pkg::MAX_DIGITS_DEF;
   localparam int DIG_W        = b2da_pkg::DIGIT_W;
   localparam int CHR_W        = b2da_pkg::CHAR_W;
   localparam int N_DIRECTED   = 16;
   localparam int N_PER_PHASE  = 40;
   localparam int MAX_GAP      = 20;
   localparam int DRAIN_CYCLES = 3 * (VBITS + NDIGITS + 2);
   localparam logic [VBITS-1:0] VALUE_TOP = {VBITS{1'b1}};

   typedef struct {
      logic [CHR_W-1:0] ch;
      logic             last;
   } digit_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [VBITS-1:0] req_value;
   logic             rsp_valid;
   logic [CHR_W-1:0] rsp_digit_char;
   logic             rsp_last;

   digit_type digits_due[$];
   digit_type oldest_due;
   int        errors = 0;

   // zero, one, nine, ten, 1000000000 and the largest value have their text given, empty text means predict
   logic [VBITS-1:0] dir_value [N_DIRECTED] = '{
      31'd0, 31'd1, 31'd9, 31'd10, 31'd99, 31'd100, 31'd2147483647, 31'd1000000000,
      31'd999999999, 31'h55555555, 31'h2AAAAAAA, 31'd1073741824, 31'd12345,
      31'd2147483646, 31'd1000000001, 31'd7
   };
   string dir_text [N_DIRECTED] = '{
      "0", "1", "9", "10", "", "", "2147483647", "1000000000",
      "", "", "", "", "", "", "", ""
   };

   binary_to_decimal_ascii i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // decimal digits of one value, most significant first, low digits kept
   function automatic void queue_decimal_digits(input logic [VBITS-1:0] value);
      logic [DIG_W-1:0] low_first [20];
      longint unsigned  v;
      int               count;
      int               k;
      digit_type        d;
      v = value & VALUE_TOP;
      count = 0;
      do begin
         low_first[count] = DIG_W'(v % 10);
         v = v / 10;
         count++;
      end while (v != 0 && count < NDIGITS && count < 20);
      for (k = 0; k < count; k++) begin
         d.ch   = b2da_pkg::ASCII_ZERO + CHR_W'(low_first[count - 1 - k]);
         d.last = (k == count - 1);
         digits_due.push_back(d);
      end
   endfunction

   function automatic void queue_text_digits(input string text);
      byte       c;
      int        i;
      digit_type d;
      for (i = 0; i < text.len(); i++) begin
         c      = text[i];
         d.ch   = c[CHR_W-1:0];
         d.last = (i == text.len() - 1);
         digits_due.push_back(d);
      end
   endfunction

   // random value of a random decimal length, raw bits, a decade edge or a small value
   function automatic logic [VBITS-1:0] pick_value();
      int              kind;
      int              ndig;
      int              i;
      longint unsigned lo;
      longint unsigned hi;
      kind = $urandom_range(9);
      ndig = $urandom_range(NDIGITS, 1);
      lo = 1;
      for (i = 1; i < ndig; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > longint'(VALUE_TOP)) hi = VALUE_TOP;
      if (ndig == 1) lo = 0;
      case (kind)
         0, 1, 2, 3, 4, 5: begin
            return VBITS'($urandom_range(32'(hi), 32'(lo)));
         end
         6, 7: begin
            return VBITS'($urandom);
         end
         8: begin
            return $urandom_range(1) ? VBITS'(hi) : VBITS'(lo);
         end
         default: begin
            return VBITS'($urandom_range(20));
         end
      endcase
   endfunction

   // called at a rising edge, returns at the rising edge of the transfer
   task automatic offer_value(input logic [VBITS-1:0] value, input string text,
                              input int idle_pct);
      int gap;
      bit took;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      // idle cycles count only once the block could take a transfer
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= VBITS'($urandom);
         while (gap > 0) begin
            @(negedge clock);
            if (!busy) gap--;
            @(posedge clock);
         end
      end
      start     <= 1'b1;
      req_value <= value;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
      if (text.len() != 0) queue_text_digits(text);
      else queue_decimal_digits(value);
   endtask

   // results cannot be stalled, so each strobe is one transfer
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (digits_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected digit: char=%h last=%b", rsp_digit_char, rsp_last);
         end else begin
            oldest_due = digits_due.pop_front();
            if (rsp_digit_char !== oldest_due.ch || rsp_last !== oldest_due.last) begin
               errors++;
               if (errors <= 10)
                  $display("digit mismatch: expected char=%h last=%b, got char=%h last=%b",
                           oldest_due.ch, oldest_due.last, rsp_digit_char, rsp_last);
            end
         end
      end
   end

   initial begin
      int idle_pct [4];
      int p;
      int n;
      idle_pct  = '{0, 56, 0, 10};
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < N_DIRECTED; n++) offer_value(dir_value[n], dir_text[n], 0);

      for (p = 0; p < 4; p++)
         for (n = 0; n < N_PER_PHASE; n++) offer_value(pick_value(), "", idle_pct[p]);

      start <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/b2da_pkg.sv
design/b2da_bcd_reg.sv
design/binary_to_decimal_ascii.sv
tb/sv/binary_to_decimal_ascii_tb.sv
